FILE: rtl/sdlcd_pkg.sv
// Shared types, codes and segment map for the segment/dot LCD write controller.
package sdlcd_pkg;

	localparam int NUM_CELLS_DEF     = 16;
	localparam int VISIBLE_CELLS_DEF = 12;
	localparam logic [7:0] SETTLE_RESET = 8'd25;
	localparam logic [3:0] CURSOR_CTRL_CELL = 4'd12;

	localparam logic [2:0] FN_BYTE  = 3'd0;
	localparam logic [2:0] FN_WORD  = 3'd1;
	localparam logic [2:0] FN_TICK  = 3'd2;
	localparam logic [2:0] FN_BLINK = 3'd3;
	localparam logic [2:0] FN_READ  = 3'd4;

	// bit 5 = entry used, bits 4:3 digit, bits 2:0 segment
	localparam logic [5:0] SEG_MAP [6][5] = '{
		'{6'h21, 6'h23, 6'h24, 6'h26, 6'h25},
		'{6'h22, 6'h20, 6'h29, 6'h2B, 6'h2C},
		'{6'h2E, 6'h2D, 6'h2A, 6'h28, 6'h31},
		'{6'h33, 6'h34, 6'h36, 6'h35, 6'h32},
		'{6'h30, 6'h39, 6'h3B, 6'h3C, 6'h3E},
		'{6'h3D, 6'h3A, 6'h38, 6'h00, 6'h00}
	};

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  offset;
		logic [15:0] write_data;
	} item_t;

	typedef struct packed {
		logic [24:0] published_mask;
		logic [9:0]  annunciators;
		logic [27:0] digit_segments;
		logic [3:0]  cursor_position;
		logic        cursor_style;
		logic        cursor_visible;
		logic [6:0]  pixel_column;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LO, ST_HI, ST_OP, ST_RD, ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic wr_lo;
		logic wr_hi;
		logic op;
		logic rd_step;
	} ctl_t;

	typedef struct packed {
		logic [2:0] func;
		logic       rd_last;
	} status_t;

endpackage

FILE: rtl/sdlcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdlcd_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/sdlcd_ctrl.sv
// Controller state machine: sequences byte and word writes, tick, blink and no-op items, and column reads.
module sdlcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        start_func,
	input  sdlcd_pkg::status_t stat,
	output sdlcd_pkg::ctl_t   cmd,
	output logic              busy,
	output logic              done
);
	import sdlcd_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (start_func == FN_BYTE || start_func == FN_WORD)
						state_nxt = ST_LO;
					else if (start_func == FN_READ)
						state_nxt = ST_RD;
					else
						state_nxt = ST_OP;
				end
			end
			ST_LO:   state_nxt = (stat.func == FN_WORD) ? ST_HI : ST_DONE;
			ST_HI:   state_nxt = ST_DONE;
			ST_OP:   state_nxt = ST_DONE;
			ST_RD:   state_nxt = stat.rd_last ? ST_DONE : ST_RD;
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.wr_lo   = (state_q == ST_LO);
		cmd.wr_hi   = (state_q == ST_HI);
		cmd.op      = (state_q == ST_OP);
		cmd.rd_step = (state_q == ST_RD);
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_DONE);
	end
endmodule

FILE: rtl/sdlcd_dp.sv
// Datapath: display state, dirty tracking, settle timer and pixel memory.
module sdlcd_dp #(
	parameter int NUM_CELLS     = sdlcd_pkg::NUM_CELLS_DEF,
	parameter int VISIBLE_CELLS = sdlcd_pkg::VISIBLE_CELLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sdlcd_pkg::ctl_t    cmd,
	input  sdlcd_pkg::item_t   item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	output sdlcd_pkg::status_t stat,
	output sdlcd_pkg::result_t result
);
	import sdlcd_pkg::*;

	localparam int CELL_W = $clog2(NUM_CELLS);
	localparam int DEPTH  = NUM_CELLS * 8;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [5:0] NC6  = 6'(NUM_CELLS);
	localparam logic [4:0] VIS5 = 5'(VISIBLE_CELLS);
	localparam logic [7:0] COLS = 8'(NUM_CELLS * 5);

	logic [2:0]  func_q;
	logic [6:0]  ofs_q;
	logic [15:0] data_q;
	logic [7:0]  settle_q;
	logic [6:0]  digit_q [4];
	logic [9:0]  ann_q;
	logic [3:0]  cur_cell_q;
	logic        cur_form_q;
	logic        cur_phase_q;
	logic [24:0] pend_q;
	logic [7:0]  timer_q;
	logic [24:0] pub_q;
	logic [6:0]  col_q;
	logic [2:0]  rd_cnt_q;
	logic [DEPTH-1:0] valid_q;
	logic        rvalid_s1;

	// byte write decode
	logic        hi_sel;
	logic [7:0]  b;
	logic [6:0]  bofs;
	logic [2:0]  line;
	logic [3:0]  cell4;
	logic [2:0]  seg_row;
	logic [5:0]  e;
	logic [6:0]  n_digit [4];
	logic [9:0]  n_ann;
	logic [3:0]  n_cell;
	logic        n_form;
	logic [24:0] mark_bits;
	logic        mark_en;
	logic        pix_we;
	logic [ADDR_W-1:0] pix_addr;

	always_comb begin
		hi_sel   = cmd.wr_hi;
		b        = hi_sel ? data_q[15:8] : data_q[7:0];
		bofs     = hi_sel ? (ofs_q | 7'd1) : ofs_q;
		line     = bofs[2:0];
		cell4    = bofs[6:3];
		seg_row  = 3'(cell4 - 4'd6);
		e        = '0;
		n_digit  = digit_q;
		n_ann    = ann_q;
		n_cell   = cur_cell_q;
		n_form   = cur_form_q;
		mark_bits = '0;
		mark_en  = 1'b0;
		pix_we   = 1'b0;
		pix_addr = ADDR_W'({CELL_W'(cell4), line});
		if (line != 3'd0) begin
			if ({2'b00, cell4} < NC6) begin
				pix_we = 1'b1;
				if ({1'b0, cell4} < VIS5) begin
					mark_bits = 25'd1 << cell4;
					mark_en   = 1'b1;
				end
			end
		end else begin
			unique case (cell4)
				4'd0: begin
					n_ann[2:0] = b[2:0];
					mark_bits  = 25'h7 << 16;
					mark_en    = 1'b1;
				end
				4'd1: begin
					n_ann[4:3] = b[1:0];
					n_ann[5]   = b[4];
					mark_bits  = 25'h7 << 19;
					mark_en    = 1'b1;
				end
				4'd3: begin n_ann[6] = b[0]; mark_bits[22] = 1'b1; mark_en = 1'b1; end
				4'd4: begin n_ann[7] = b[0]; mark_bits[23] = 1'b1; mark_en = 1'b1; end
				4'd5: begin n_ann[8] = b[0]; mark_bits[24] = 1'b1; mark_en = 1'b1; end
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
					for (int i = 0; i < 5; i++) begin
						e = SEG_MAP[seg_row][i];
						if (e[5]) begin
							n_digit[e[4:3]][e[2:0]] = b[i];
							mark_bits[12 + int'(e[4:3])] = 1'b1;
						end
					end
					if (cell4 == 4'd11)
						n_ann[9] = b[3];
					mark_en = 1'b1;
				end
				CURSOR_CTRL_CELL: begin
					n_form = b[4];
					if (b[3:0] != cur_cell_q) begin
						if ({1'b0, b[3:0]} < VIS5) begin
							mark_bits = mark_bits | (25'd1 << b[3:0]);
							mark_en   = 1'b1;
						end
						if ({1'b0, cur_cell_q} < VIS5) begin
							mark_bits = mark_bits | (25'd1 << cur_cell_q);
							mark_en   = 1'b1;
						end
						n_cell = b[3:0];
					end
				end
				default: ;
			endcase
		end
	end

	// column read: cell = x/5 by reciprocal, exact for 7-bit x
	logic [14:0] recip;
	logic [4:0]  rd_cell;
	logic [2:0]  col_i;
	logic        in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [4:0]  ram_rdata;

	always_comb begin
		recip    = 15'(ofs_q) * 15'd205;
		rd_cell  = recip[14:10];
		col_i    = 3'(ofs_q - 7'(rd_cell) * 7'd5);
		in_range = {1'b0, ofs_q} < COLS;
		rd_addr  = ADDR_W'({CELL_W'(rd_cell), 3'(rd_cnt_q + 3'd1)});
	end

	sdlcd_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (pix_we && (cmd.wr_lo || cmd.wr_hi)),
		.waddr (pix_addr),
		.wdata (b[4:0]),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q    <= SETTLE_RESET;
			for (int k = 0; k < 4; k++)
				digit_q[k] <= '0;
			ann_q       <= '0;
			cur_cell_q  <= '0;
			cur_form_q  <= 1'b0;
			cur_phase_q <= 1'b0;
			pend_q      <= '0;
			timer_q     <= '0;
			valid_q     <= '0;
			rd_cnt_q    <= '0;
		end else begin
			if (cfg_we)
				settle_q <= cfg_data;
			if (cmd.load)
				rd_cnt_q <= '0;
			if (cmd.wr_lo || cmd.wr_hi) begin
				digit_q    <= n_digit;
				ann_q      <= n_ann;
				cur_cell_q <= n_cell;
				cur_form_q <= n_form;
				if (pix_we)
					valid_q[pix_addr] <= 1'b1;
				if (mark_en) begin
					pend_q  <= pend_q | mark_bits;
					timer_q <= settle_q;
				end
			end
			if (cmd.op) begin
				if (func_q == FN_TICK) begin
					if (timer_q == 8'd0)
						pend_q <= '0;
					else
						timer_q <= timer_q - 8'd1;
				end else if (func_q == FN_BLINK) begin
					cur_phase_q <= ~cur_phase_q;
					if ({1'b0, cur_cell_q} < VIS5) begin
						pend_q  <= pend_q | (25'd1 << cur_cell_q);
						timer_q <= settle_q;
					end
				end
			end
			if (cmd.rd_step)
				rd_cnt_q <= rd_cnt_q + 3'd1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= item.func;
			ofs_q  <= item.offset;
			data_q <= item.write_data;
			pub_q  <= '0;
			col_q  <= '0;
		end
		if (cmd.op && func_q == FN_TICK && timer_q == 8'd0)
			pub_q <= pend_q;
		rvalid_s1 <= in_range ? valid_q[rd_addr] : 1'b0;
		if (cmd.rd_step && rd_cnt_q != 3'd0)
			col_q[3'(rd_cnt_q - 3'd1)] <= in_range && rvalid_s1 && ram_rdata[col_i];
	end

	always_comb begin
		stat.func    = func_q;
		stat.rd_last = (rd_cnt_q == 3'd7);
		result.published_mask  = pub_q;
		result.annunciators    = ann_q;
		result.digit_segments  = {digit_q[3], digit_q[2], digit_q[1], digit_q[0]};
		result.cursor_position = cur_cell_q;
		result.cursor_style    = cur_form_q;
		result.cursor_visible  = cur_phase_q;
		result.pixel_column    = col_q;
	end
endmodule

FILE: rtl/segment_dot_lcd_write_controller.sv
// Top level of the segment/dot LCD write controller.
// An item is taken when start is high and busy is low; its result appears for one
// cycle with done high. A byte write writes one byte lane, a word write its low then
// its high lane, tick, blink and no-op items take an operation step, and a pixel column
// read reads the seven row words of the column's cell one per cycle from the pixel RAM.
// The result must be taken in its done cycle; it is not held.
// Config writes are always ready and should be made while busy is low.
module segment_dot_lcd_write_controller #(
	parameter int NUM_CELLS     = sdlcd_pkg::NUM_CELLS_DEF,
	parameter int VISIBLE_CELLS = sdlcd_pkg::VISIBLE_CELLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sdlcd_pkg::item_t   item,
	output logic               busy,
	output logic               done,
	output sdlcd_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import sdlcd_pkg::*;

	ctl_t    cmd;
	status_t stat;

	assign cfg_ready = 1'b1;

	sdlcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_func (item.func),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	sdlcd_dp #(.NUM_CELLS(NUM_CELLS), .VISIBLE_CELLS(VISIBLE_CELLS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("beat accepted but not busy");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.wr_lo, cmd.wr_hi, cmd.op, cmd.rd_step}))
		else $error("overlapping datapath commands");
`endif
endmodule

FILE: sim/tb_segment_dot_lcd_write_controller.sv
// Self-checking testbench for the segment/dot LCD write controller, with a class-based scoreboard.
module tb_segment_dot_lcd_write_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import sdlcd_pkg::*;

	localparam int COLS  = NUM_CELLS_DEF * 5;
	localparam int WDOG  = 4000;

	class lcd_scoreboard;
		logic [7:0]  settle;
		logic [6:0]  pixels [COLS];
		logic [6:0]  digits [4];
		logic [9:0]  annun;
		logic [3:0]  cur_cell;
		logic        cur_form;
		logic        cur_phase;
		logic [24:0] pending;
		logic [7:0]  timer;
		result_t     expected_q [$];
		int          errors;

		function new();
			settle = SETTLE_RESET;
			foreach (pixels[i]) pixels[i] = '0;
			foreach (digits[i]) digits[i] = '0;
			annun = '0;
			cur_cell = '0;
			cur_form = 1'b0;
			cur_phase = 1'b0;
			pending = '0;
			timer = '0;
			errors = 0;
		endfunction

		function void touch(logic [24:0] bits);
			pending |= bits;
			timer = settle;
		endfunction

		function void lcd_byte(logic [6:0] ofs, logic [7:0] b);
			logic [3:0]  cidx;
			logic [2:0]  line;
			logic [24:0] d;
			logic [5:0]  e;
			cidx = ofs[6:3];
			line = ofs[2:0];
			d = '0;
			if (line != 0) begin
				for (int i = 0; i < 5; i++)
					pixels[cidx * 5 + i][line - 1] = b[i];
				if (cidx < VISIBLE_CELLS_DEF)
					touch(25'd1 << cidx);
				return;
			end
			case (cidx)
				4'd0: begin
					annun[2:0] = b[2:0];
					touch(25'h7 << 16);
				end
				4'd1: begin
					annun[3] = b[0];
					annun[4] = b[1];
					annun[5] = b[4];
					touch(25'h7 << 19);
				end
				4'd3: begin annun[6] = b[0]; touch(25'd1 << 22); end
				4'd4: begin annun[7] = b[0]; touch(25'd1 << 23); end
				4'd5: begin annun[8] = b[0]; touch(25'd1 << 24); end
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
					for (int i = 0; i < 5; i++) begin
						e = SEG_MAP[cidx - 6][i];
						if (e[5]) begin
							digits[e[4:3]][e[2:0]] = b[i];
							d[12 + e[4:3]] = 1'b1;
						end
					end
					if (cidx == 4'd11)
						annun[9] = b[3];
					touch(d);
				end
				CURSOR_CTRL_CELL: begin
					cur_form = b[4];
					if (b[3:0] != cur_cell) begin
						if (b[3:0] < VISIBLE_CELLS_DEF)
							touch(25'd1 << b[3:0]);
						if (cur_cell < VISIBLE_CELLS_DEF)
							touch(25'd1 << cur_cell);
						cur_cell = b[3:0];
					end
				end
				default: ;
			endcase
		endfunction

		function void note_item(item_t it);
			result_t r;
			r = '0;
			case (it.func)
				FN_BYTE: lcd_byte(it.offset, it.write_data[7:0]);
				FN_WORD: begin
					lcd_byte(it.offset, it.write_data[7:0]);
					lcd_byte(it.offset | 7'd1, it.write_data[15:8]);
				end
				FN_TICK: begin
					if (timer == 0) begin
						r.published_mask = pending;
						pending = '0;
					end else
						timer--;
				end
				FN_BLINK: begin
					cur_phase = ~cur_phase;
					if (cur_cell < VISIBLE_CELLS_DEF)
						touch(25'd1 << cur_cell);
				end
				FN_READ: begin
					if (it.offset < COLS)
						r.pixel_column = pixels[it.offset];
				end
				default: ;
			endcase
			r.annunciators = annun;
			for (int k = 0; k < 4; k++)
				r.digit_segments[7 * k +: 7] = digits[k];
			r.cursor_position = cur_cell;
			r.cursor_style = cur_form;
			r.cursor_visible = cur_phase;
			expected_q.push_back(r);
		endfunction

		function void cmp(string fld, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
			end
		endfunction

		function void check_result(result_t a);
			result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				return;
			end
			e = expected_q.pop_front();
			cmp("published_mask", e.published_mask, a.published_mask);
			cmp("annunciators", e.annunciators, a.annunciators);
			cmp("digit_segments", e.digit_segments, a.digit_segments);
			cmp("cursor_position", e.cursor_position, a.cursor_position);
			cmp("cursor_style", e.cursor_style, a.cursor_style);
			cmp("cursor_visible", e.cursor_visible, a.cursor_visible);
			cmp("pixel_column", e.pixel_column, a.pixel_column);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	item_t      item = '0;
	logic       busy, done, cfg_ready;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = '0;
	int         quiet = 0;

	lcd_scoreboard sb = new();

	segment_dot_lcd_write_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_result(result);
	end

	// watchdog: cycles with no beat on any port
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (arst_n) begin
			quiet <= quiet + 1;
			if (quiet >= WDOG) begin
				$display("tb_segment_dot_lcd_write_controller failed");
				$finish;
			end
		end
	end

	task automatic send(item_t it, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_settle(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.settle = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t mk(logic [2:0] f, logic [6:0] o, logic [15:0] d);
		item_t it;
		it.func = f;
		it.offset = o;
		it.write_data = d;
		return it;
	endfunction

	function automatic item_t rand_item();
		int r;
		logic [6:0] o;
		r = $urandom_range(99);
		// line 0 gets a good share so the maps and cursor see plenty of traffic
		if ($urandom_range(99) < 40)
			o = {4'($urandom_range(15)), 3'd0};
		else
			o = 7'($urandom_range(127));
		if (r < 35) return mk(FN_BYTE, o, 16'($urandom));
		if (r < 50) return mk(FN_WORD, o, 16'($urandom));
		if (r < 75) return mk(FN_TICK, 7'($urandom), 16'($urandom));
		if (r < 82) return mk(FN_BLINK, 7'($urandom), 16'($urandom));
		if (r < 94) return mk(FN_READ, 7'($urandom_range(127)), 16'($urandom));
		return mk(3'($urandom_range(5, 7)), 7'($urandom), 16'($urandom));
	endfunction

	initial begin
		logic [7:0] settles [4];
		int         idles [4];
		settles = '{8'd0, 8'd3, 8'd255, 8'd1};
		idles = '{0, 61, 0, 25};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: line-0 cells 0 to 13, pixel extremes, cursor, blink, reads, tick, no-ops
		for (int c = 0; c <= 13; c++)
			send(mk(FN_BYTE, 7'(c * 8), 16'h00ff), 0);
		send(mk(FN_BYTE, 7'd1, 16'h00ff), 0);
		send(mk(FN_BYTE, 7'd127, 16'h001f), 0);
		send(mk(FN_WORD, 7'd98, 16'hffff), 0);
		send(mk(FN_BYTE, 7'd96, 16'h0015), 0);
		send(mk(FN_BYTE, 7'd96, 16'h000e), 0);
		send(mk(FN_BLINK, 7'd0, 16'h0000), 0);
		send(mk(FN_READ, 7'd0, 16'h0000), 0);
		send(mk(FN_READ, 7'd79, 16'h0000), 0);
		send(mk(FN_READ, 7'd127, 16'h0000), 0);
		send(mk(FN_TICK, 7'd0, 16'h0000), 0);
		send(mk(3'd7, 7'd0, 16'h0000), 0);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_settle(settles[p]);
			for (int n = 0; n < 225; n++)
				send(rand_item(), idles[p]);
			drain();
		end

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_segment_dot_lcd_write_controller passed");
		else
			$display("tb_segment_dot_lcd_write_controller failed");
		$finish;
	end
endmodule
